@@ src/ptpg_pkg.sv @@
`default_nettype none

package ptpg_pkg;

    localparam int ROW_W        = 12;
    localparam int SIZE_W       = 12;
    localparam int DIM_W        = 13;
    localparam int COLOUR_W     = 24;
    localparam int CFG_IDX_W    = 3;
    localparam int MODE_W       = 3;
    localparam int SINE_ENTRIES = 1024;
    localparam int SINE_W       = 17;
    localparam int PIPE_DEPTH   = 47;
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

    typedef enum logic [MODE_W-1:0] {
        MODE_CHESS   = 3'd0,
        MODE_ZEBRA   = 3'd1,
        MODE_DIAMOND = 3'd2,
        MODE_SNAKE   = 3'd3,
        MODE_RINGS   = 3'd4,
        MODE_BRICKS  = 3'd5
    } mode_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_MODE = 3'd0,
        REG_SQUARE_SIZE  = 3'd1,
        REG_IMAGE_HEIGHT = 3'd2,
        REG_IMAGE_WIDTH  = 3'd3,
        REG_MAIN_COLOUR  = 3'd4,
        REG_BACK_COLOUR  = 3'd5
    } reg_idx_e;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [SIZE_W-1:0]   size;
        logic [DIM_W-1:0]    height;
        logic [DIM_W-1:0]    width;
        logic [COLOUR_W-1:0] main_colour;
        logic [COLOUR_W-1:0] back_colour;
    } cfg_t;

    typedef logic [SINE_W-1:0] sine_tab_t [0:SINE_ENTRIES];

    function automatic sine_tab_t sine_table_build();
        sine_tab_t       tab;
        longint unsigned x;
        longint unsigned term;
        longint unsigned v;
        longint          sum;
        int              k;
        int              n;
        for (k = 0; k <= SINE_ENTRIES; k++)
        begin
            x    = (PI_HALF_Q30 * 64'(k)) / SINE_ENTRIES;
            term = x;
            sum  = longint'(x);
            for (n = 1; n <= 12; n++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1)
                begin
                    sum = sum - longint'(term);
                end
                else
                begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            v = sum;
            v = (v + 64'd8192) >> 14;
            if (v > 64'd65536)
            begin
                v = 64'd65536;
            end
            tab[k] = v[SINE_W-1:0];
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TABLE = sine_table_build();

endpackage

`default_nettype wire

@@ src/procedural_texture_pattern_generator_core.sv @@
// procedural texture pattern generator
// pixel channel: drive pixel_row and pixel_column with start high; a transaction
// is taken at every rising edge where start is high and busy is low. busy stays
// low, so one pixel can be taken in every clock cycle.
// result channel: done is high for exactly one cycle with red, green, blue and
// is_foreground; results leave in the order the pixels came in.
// done and the result are taken from the last register of the pipeline.
// the longest path is the snake phase division (remainder of row by height,
// then a 13-step quotient), the sine rom read, the offset multiply and a
// 14-step division by the cell size; other patterns ride the same stages.
// configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. write registers only while no pixel is in flight.
// reset clears the in-flight valid bits and loads the register defaults
// (chess, size 1, 100 by 100, white on black). the receiver cannot stall.
`default_nettype none

module procedural_texture_pattern_generator_core
    import ptpg_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [ROW_W-1:0]     pixel_row,
    input  wire logic [ROW_W-1:0]     pixel_column,
    output logic                      done,
    output logic [7:0]                red,
    output logic [7:0]                green,
    output logic [7:0]                blue,
    output logic                      is_foreground,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COLOUR_W-1:0]  cfg_data
);

    typedef struct packed {
        logic [11:0] row;
        logic [11:0] col;
        logic [12:0] hrem;
        logic [25:0] prem;
        logic [12:0] pquo;
        logic [11:0] dxm;
        logic [11:0] dym;
        logic [23:0] dx2;
        logic [23:0] dy2;
        logic [25:0] d2;
        logic [13:0] qrem;
        logic [12:0] root;
        logic        sneg;
        logic [10:0] saddr;
        logic [30:0] prod;
        logic [13:0] emag;
        logic [13:0] na;
        logic [13:0] nb;
        logic [13:0] nc;
        logic [11:0] ra;
        logic [11:0] rb;
        logic [11:0] rc;
        logic        qa;
        logic        qb;
        logic        qc;
        logic [11:0] dpx;
        logic [11:0] dpy;
        logic        fg;
        logic [23:0] colour;
    } pipe_t;

    cfg_t                cfg;
    logic [SIZE_W-1:0]   s_eff;
    logic [DIM_W-1:0]    h_eff;
    logic                accept;
    pipe_t               in_word;
    logic [PIPE_DEPTH:0] vld_reg;
    pipe_t               stg_reg  [0:PIPE_DEPTH];
    pipe_t               stg_next [0:PIPE_DEPTH-1];
    logic [SINE_W-1:0]   rom_data_reg;

    ptpg_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign s_eff     = (cfg.size == '0) ? 12'd1 : cfg.size;
    assign h_eff     = (cfg.height == '0) ? 13'd1 : cfg.height;

    function automatic logic [12:0] div_bit(input logic [11:0] rem, input logic nbit,
                                            input logic [11:0] s);
        logic [12:0] tr;
        logic [12:0] dif;
        tr  = {rem, nbit};
        dif = tr - {1'b0, s};
        if (tr >= {1'b0, s})
        begin
            return {1'b1, dif[11:0]};
        end
        return {1'b0, tr[11:0]};
    endfunction

    function automatic pipe_t pipe_step(input int k, input pipe_t x, input cfg_t c,
                                        input logic [11:0] s, input logic [12:0] h,
                                        input logic [16:0] rom);
        pipe_t       y;
        logic [13:0] tr14;
        logic [13:0] base14;
        logic [12:0] dx;
        logic [12:0] dy;
        logic [26:0] dsh;
        logic [15:0] sq_t;
        logic [15:0] sq_d;
        logic [14:0] sq_trial;
        logic [13:0] om;
        logic [14:0] esum;
        logic [14:0] eneg;
        logic [13:0] s3;
        logic [12:0] da;
        logic [12:0] db;
        logic [12:0] dc;
        logic [11:0] rbase_a;
        logic [11:0] rbase_b;
        logic [11:0] rbase_c;
        logic [12:0] dsum;
        int          t;
        y = x;
        if (k == 0)
        begin
            dx = {1'b0, x.col} - {1'b0, c.width[12:1]};
            dy = {1'b0, x.row} - {1'b0, c.height[12:1]};
            y.dxm = dx[12] ? 12'(-dx) : dx[11:0];
            y.dym = dy[12] ? 12'(-dy) : dy[11:0];
        end
        if (k <= 11)
        begin
            t      = 11 - k;
            base14 = (k == 0) ? 14'd0 : {1'b0, x.hrem};
            tr14   = {base14[12:0], x.row[t]};
            if (tr14 >= {1'b0, h})
            begin
                tr14 = tr14 - {1'b0, h};
            end
            y.hrem = tr14[12:0];
        end
        if (k == 1)
        begin
            y.dx2 = {12'd0, x.dxm} * {12'd0, x.dxm};
            y.dy2 = {12'd0, x.dym} * {12'd0, x.dym};
        end
        if (k == 2)
        begin
            y.d2 = {2'b0, x.dx2} + {2'b0, x.dy2};
        end
        if ((k >= 3) && (k <= 15))
        begin
            t        = 15 - k;
            sq_t     = {((k == 3) ? 14'd0 : x.qrem), x.d2[2*t +: 2]};
            sq_trial = {((k == 3) ? 13'd0 : x.root), 2'b01};
            sq_d     = sq_t - {1'b0, sq_trial};
            if (sq_t >= {1'b0, sq_trial})
            begin
                y.qrem = sq_d[13:0];
                y.root = {((k == 3) ? 12'd0 : x.root[11:0]), 1'b1};
            end
            else
            begin
                y.qrem = sq_t[13:0];
                y.root = {((k == 3) ? 12'd0 : x.root[11:0]), 1'b0};
            end
        end
        if (k == 12)
        begin
            y.prem = {x.hrem, 13'd0} + {13'd0, h};
            y.pquo = '0;
        end
        if ((k >= 13) && (k <= 25))
        begin
            t   = 25 - k;
            dsh = {13'd0, h, 1'b0} << t;
            if ({1'b0, x.prem} >= dsh)
            begin
                y.prem    = x.prem - dsh[25:0];
                y.pquo[t] = 1'b1;
            end
        end
        if (k == 26)
        begin
            y.sneg  = x.pquo[11];
            y.saddr = x.pquo[10] ? (11'd1024 - {1'b0, x.pquo[9:0]}) : {1'b0, x.pquo[9:0]};
        end
        if (k == 28)
        begin
            s3     = {2'b0, s} + {1'b0, s, 1'b0};
            y.prod = {17'd0, s3} * {14'd0, rom};
        end
        if (k == 29)
        begin
            om   = x.prod[30:17];
            esum = x.sneg ? ({3'd0, x.col} - {1'b0, om}) : ({3'd0, x.col} + {1'b0, om});
            eneg = 15'd0 - esum;
            y.emag = esum[14] ? eneg[13:0] : esum[13:0];
        end
        if (k == 30)
        begin
            y.na = '0;
            y.nb = '0;
            y.nc = '0;
            unique case (c.mode)
                MODE_CHESS:
                begin
                    y.na = {2'b0, x.row};
                    y.nb = {2'b0, x.col};
                end
                MODE_ZEBRA:   y.na = {2'b0, x.row} + {2'b0, x.col};
                MODE_DIAMOND:
                begin
                    y.na = {2'b0, x.col};
                    y.nb = {2'b0, x.row};
                end
                MODE_SNAKE:   y.na = x.emag;
                MODE_RINGS:   y.na = {1'b0, x.root};
                MODE_BRICKS:
                begin
                    y.na = {2'b0, x.col};
                    y.nb = {2'b0, x.row};
                    y.nc = {2'b0, x.col} + {3'b0, s[11:1]};
                end
                default:      y.na = '0;
            endcase
        end
        if ((k >= 31) && (k <= 44))
        begin
            t       = 44 - k;
            rbase_a = (k == 31) ? 12'd0 : x.ra;
            rbase_b = (k == 31) ? 12'd0 : x.rb;
            rbase_c = (k == 31) ? 12'd0 : x.rc;
            da      = div_bit(rbase_a, x.na[t], s);
            db      = div_bit(rbase_b, x.nb[t], s);
            dc      = div_bit(rbase_c, x.nc[t], s);
            {y.qa, y.ra} = da;
            {y.qb, y.rb} = db;
            {y.qc, y.rc} = dc;
        end
        if (k == 45)
        begin
            y.dpx = x.qa ? x.ra : (s - x.ra);
            y.dpy = x.qb ? x.rb : (s - x.rb);
        end
        if (k == 46)
        begin
            dsum = {1'b0, x.dpx} + {1'b0, x.dpy};
            unique case (c.mode)
                MODE_CHESS:   y.fg = (x.qa == x.qb);
                MODE_ZEBRA:   y.fg = !x.qa;
                MODE_DIAMOND: y.fg = (dsum <= {1'b0, s});
                MODE_SNAKE:   y.fg = !x.qa;
                MODE_RINGS:   y.fg = !x.qa;
                MODE_BRICKS:  y.fg = x.qb ? !x.qc : !x.qa;
                default:      y.fg = 1'b0;
            endcase
            y.colour = y.fg ? c.main_colour : c.back_colour;
        end
        return y;
    endfunction

    always_comb
    begin
        in_word     = '0;
        in_word.row = pixel_row;
        in_word.col = pixel_column;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-1:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        stg_reg[0]   <= in_word;
        rom_data_reg <= SINE_TABLE[stg_reg[27].saddr];
    end

    for (genvar g = 0; g < PIPE_DEPTH; g++)
    begin : g_stage
        always_comb
        begin
            stg_next[g] = pipe_step(g, stg_reg[g], cfg, s_eff, h_eff, rom_data_reg);
        end

        always_ff @(posedge clk)
        begin
            stg_reg[g+1] <= stg_next[g];
        end
    end

    assign done          = vld_reg[PIPE_DEPTH];
    assign red           = stg_reg[PIPE_DEPTH].colour[23:16];
    assign green         = stg_reg[PIPE_DEPTH].colour[15:8];
    assign blue          = stg_reg[PIPE_DEPTH].colour[7:0];
    assign is_foreground = stg_reg[PIPE_DEPTH].fg;

    // every accepted pixel comes out with done when it leaves the last pipeline stage
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(PIPE_DEPTH + 1) done)
        else $error("accepted pixel did not reach the output");

    // row remainder stays below the wave period
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[12] |-> (stg_reg[12].hrem < h_eff))
        else $error("row remainder out of range");

    // rounded phase never passes one full wave
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[26] |-> (stg_reg[26].pquo <= 13'd4096))
        else $error("snake phase out of range");

    // unknown pattern codes give background
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (cfg.mode != MODE_CHESS) && (cfg.mode != MODE_ZEBRA)
         && (cfg.mode != MODE_DIAMOND) && (cfg.mode != MODE_SNAKE)
         && (cfg.mode != MODE_RINGS) && (cfg.mode != MODE_BRICKS)) |-> !is_foreground)
        else $error("foreground on unknown pattern");

endmodule

`default_nettype wire

@@ src/ptpg_cfg_regs.sv @@
`default_nettype none

module ptpg_cfg_regs
    import ptpg_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [CFG_IDX_W-1:0] wr_index,
    input  wire logic [COLOUR_W-1:0]  wr_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_PATTERN_MODE: cfg_next.mode        = wr_data[MODE_W-1:0];
                REG_SQUARE_SIZE:  cfg_next.size        = wr_data[SIZE_W-1:0];
                REG_IMAGE_HEIGHT: cfg_next.height      = wr_data[DIM_W-1:0];
                REG_IMAGE_WIDTH:  cfg_next.width       = wr_data[DIM_W-1:0];
                REG_MAIN_COLOUR:  cfg_next.main_colour = wr_data;
                REG_BACK_COLOUR:  cfg_next.back_colour = wr_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode        <= MODE_CHESS;
            cfg_reg.size        <= 12'd1;
            cfg_reg.height      <= 13'd100;
            cfg_reg.width       <= 13'd100;
            cfg_reg.main_colour <= 24'hFFFFFF;
            cfg_reg.back_colour <= 24'h000000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`default_nettype none

module tb
    import ptpg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int               WATCHDOG_LIMIT = 1000;
    localparam int               DRAIN_CYCLES   = PIPE_DEPTH + 10;
    localparam logic [MODE_W-1:0] MODE_UNUSED_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       fg;
    } pixel_colour_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [ROW_W-1:0]     pixel_row = '0;
    logic [ROW_W-1:0]     pixel_column = '0;
    logic                 done;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic                 is_foreground;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COLOUR_W-1:0]  cfg_data = '0;

    // predictor copy of the registers
    logic [MODE_W-1:0]    cur_mode;
    logic [SIZE_W-1:0]    cur_size;
    logic [DIM_W-1:0]     cur_height;
    logic [DIM_W-1:0]     cur_width;
    logic [COLOUR_W-1:0]  cur_main;
    logic [COLOUR_W-1:0]  cur_back;

    longint unsigned      quarter_sine [0:SINE_ENTRIES];
    pixel_colour_t        expected_pixels [$];
    int                   pixels_sent = 0;
    int                   pixels_checked = 0;
    int                   cfg_writes = 0;
    int                   errors = 0;
    int                   idle_cycles = 0;
    bit [7:0]             modes_seen = '0;

    procedural_texture_pattern_generator_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .pixel_row     (pixel_row),
        .pixel_column  (pixel_column),
        .done          (done),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .is_foreground (is_foreground),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void fill_quarter_sine();
        longint unsigned x;
        longint unsigned term;
        longint unsigned v;
        longint          acc;
        for (int k = 0; k <= SINE_ENTRIES; k++)
        begin
            x   = (PI_HALF_Q30 * longint'(k)) / SINE_ENTRIES;
            term = x;
            acc  = longint'(x);
            for (int n = 1; n <= 12; n++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                begin
                    acc = acc - longint'(term);
                end
                else
                begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0)
            begin
                acc = 0;
            end
            v = (longint'(acc) + 64'd8192) >> 14;
            if (v > 64'd65536)
            begin
                v = 64'd65536;
            end
            quarter_sine[k] = v;
        end
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
        begin
            bitv = bitv >> 2;
        end
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic pixel_colour_t pattern_colour(logic [ROW_W-1:0] row,
                                                     logic [ROW_W-1:0] col);
        longint unsigned i;
        longint unsigned j;
        longint unsigned s;
        longint unsigned h;
        longint unsigned ph;
        longint unsigned quad;
        longint unsigned om;
        longint unsigned c;
        longint          sv;
        longint          e;
        longint          dx;
        longint          dy;
        longint          px;
        longint          py;
        logic            fg;
        logic [COLOUR_W-1:0] colour;
        pixel_colour_t   res;
        i  = row;
        j  = col;
        s  = (cur_size == 0) ? 1 : cur_size;
        fg = 1'b0;
        case (cur_mode)
            MODE_CHESS:   fg = ((i / s) & 1) == ((j / s) & 1);
            MODE_ZEBRA:   fg = (((i + j) / s) & 1) == 0;
            MODE_DIAMOND:
            begin
                px = longint'(j % (2 * s)) - longint'(s);
                py = longint'(i % (2 * s)) - longint'(s);
                fg = ((px < 0 ? -px : px) + (py < 0 ? -py : py)) <= longint'(s);
            end
            MODE_SNAKE:
            begin
                h    = (cur_height == 0) ? 1 : cur_height;
                ph   = ((i * 4 * SINE_ENTRIES * 2 + h) / (2 * h)) % (4 * SINE_ENTRIES);
                quad = (ph / SINE_ENTRIES) & 3;
                if (quad == 0 || quad == 2)
                begin
                    sv = longint'(quarter_sine[ph % SINE_ENTRIES]);
                end
                else
                begin
                    sv = longint'(quarter_sine[SINE_ENTRIES - ph % SINE_ENTRIES]);
                end
                om = (3 * s * longint'(sv)) >> 17;
                e  = (quad >= 2) ? longint'(j) - longint'(om) : longint'(j) + longint'(om);
                fg = (((e < 0 ? -e : e) / longint'(s)) & 1) == 0;
            end
            MODE_RINGS:
            begin
                dx = longint'(j) - longint'(cur_width / 2);
                dy = longint'(i) - longint'(cur_height / 2);
                fg = ((floor_sqrt(dx * dx + dy * dy) / s) & 1) == 0;
            end
            MODE_BRICKS:
            begin
                c = j / s;
                if (((i / s) & 1) != 0)
                begin
                    c = (j + s / 2) / s;
                end
                fg = (c & 1) == 0;
            end
            default:      fg = 1'b0;
        endcase
        colour    = fg ? cur_main : cur_back;
        res.red   = colour[23:16];
        res.green = colour[15:8];
        res.blue  = colour[7:0];
        res.fg    = fg;
        return res;
    endfunction

    task automatic send_pixel(input logic [ROW_W-1:0] row, input logic [ROW_W-1:0] col);
        start        <= 1'b1;
        pixel_row    <= row;
        pixel_column <= col;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        expected_pixels.push_back(pattern_colour(row, col));
        modes_seen[cur_mode] = 1'b1;
        pixels_sent++;
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_e idx, input logic [COLOUR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            REG_PATTERN_MODE: cur_mode   = value[MODE_W-1:0];
            REG_SQUARE_SIZE:  cur_size   = value[SIZE_W-1:0];
            REG_IMAGE_HEIGHT: cur_height = value[DIM_W-1:0];
            REG_IMAGE_WIDTH:  cur_width  = value[DIM_W-1:0];
            REG_MAIN_COLOUR:  cur_main   = value;
            REG_BACK_COLOUR:  cur_back   = value;
            default:          ;
        endcase
    endtask

    task automatic set_config(input logic [MODE_W-1:0] mode, input logic [SIZE_W-1:0] size,
                              input logic [DIM_W-1:0] height, input logic [DIM_W-1:0] width);
        drain();
        write_reg(REG_PATTERN_MODE, COLOUR_W'(mode));
        write_reg(REG_SQUARE_SIZE, COLOUR_W'(size));
        write_reg(REG_IMAGE_HEIGHT, COLOUR_W'(height));
        write_reg(REG_IMAGE_WIDTH, COLOUR_W'(width));
        write_reg(REG_MAIN_COLOUR, COLOUR_W'($urandom));
        write_reg(REG_BACK_COLOUR, COLOUR_W'($urandom));
    endtask

    task automatic test_reset_defaults();
        cur_mode   = MODE_CHESS;
        cur_size   = 1;
        cur_height = 100;
        cur_width  = 100;
        cur_main   = 24'hFFFFFF;
        cur_back   = 24'h000000;
        send_pixel(0, 0);
        send_pixel(0, 1);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'hFFF, 0);
    endtask

    task automatic test_directed();
        logic [MODE_W-1:0] modes [8];
        modes = '{MODE_CHESS, MODE_ZEBRA, MODE_DIAMOND, MODE_SNAKE, MODE_RINGS,
                  MODE_BRICKS, MODE_UNUSED_6, MODE_UNUSED_7};
        foreach (modes[m])
        begin
            set_config(modes[m], (m % 2 == 0) ? 12'd0 : 12'd3, 13'd100, 13'd100);
            send_pixel(0, 0);
            send_pixel(12'hFFF, 12'hFFF);
            send_pixel(12'hAAA, 12'h555);
        end
        // zero height and extreme sizes
        set_config(MODE_SNAKE, 12'd2048, 13'd0, 13'd1);
        send_pixel(12'hFFF, 12'h800);
        send_pixel(12'd77, 12'd5);
        set_config(MODE_RINGS, 12'hFFF, 13'h1FFF, 13'h1FFF);
        send_pixel(0, 12'hFFF);
    endtask

    task automatic test_random_phases();
        int                burst;
        int                count;
        logic [MODE_W-1:0] mode;
        logic [SIZE_W-1:0] size;
        logic [DIM_W-1:0]  height;
        logic [DIM_W-1:0]  width;
        for (int phase = 0; phase < 14; phase++)
        begin
            mode = ($urandom_range(0, 9) == 0) ? MODE_W'($urandom_range(6, 7))
                                               : MODE_W'(phase % 6);
            case ($urandom_range(0, 4))
                0:       size = SIZE_W'($urandom_range(0, 1));
                1:       size = SIZE_W'($urandom);
                2:       size = 12'd2048;
                default: size = SIZE_W'($urandom_range(2, 40));
            endcase
            case ($urandom_range(0, 3))
                0:       height = DIM_W'($urandom_range(0, 1));
                1:       height = DIM_W'($urandom);
                default: height = DIM_W'($urandom_range(16, 4096));
            endcase
            width = ($urandom_range(0, 3) == 0) ? DIM_W'($urandom) : DIM_W'($urandom_range(1, 4096));
            set_config(mode, size, height, width);
            burst = 0;
            count = $urandom_range(35, 55);
            for (int n = 0; n < count; n++)
            begin
                if (burst == 0)
                begin
                    hold_off((phase % 4 == 0) ? 0 : $urandom_range(0, 12));
                    burst = $urandom_range(1, 30);
                end
                send_pixel(ROW_W'($urandom), ROW_W'($urandom));
                burst--;
            end
        end
    endtask

    task automatic test_pause_until_empty();
        for (int n = 0; n < 5; n++)
        begin
            send_pixel(ROW_W'($urandom), ROW_W'($urandom));
        end
        start <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        for (int n = 0; n < 5; n++)
        begin
            send_pixel(ROW_W'($urandom), ROW_W'($urandom));
        end
    endtask

    // result check
    always @(posedge clk)
    begin
        pixel_colour_t want;
        if (rst_n && done)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected result transaction r=%h g=%h b=%h fg=%b",
                         $time, red, green, blue, is_foreground);
                errors++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                pixels_checked++;
                if (red !== want.red)
                begin
                    $display("%0t: red expected %h actual %h", $time, want.red, red);
                    errors++;
                end
                if (green !== want.green)
                begin
                    $display("%0t: green expected %h actual %h", $time, want.green, green);
                    errors++;
                end
                if (blue !== want.blue)
                begin
                    $display("%0t: blue expected %h actual %h", $time, want.blue, blue);
                    errors++;
                end
                if (is_foreground !== want.fg)
                begin
                    $display("%0t: is_foreground expected %b actual %b", $time, want.fg,
                             is_foreground);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding", expected_pixels.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        fill_quarter_sine();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed();
        test_random_phases();
        test_pause_until_empty();
        drain();
        $display("covered %0d pixels, %0d checked, %0d register writes, mode mask %b",
                 pixels_sent, pixels_checked, cfg_writes, modes_seen);
        $display("with zero size, zero height, unused modes and bursty input");
        if (errors == 0 && expected_pixels.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ procedural_texture_pattern_generator_core.f @@
src/ptpg_pkg.sv
src/ptpg_cfg_regs.sv
src/procedural_texture_pattern_generator_core.sv
verif/tb.sv
